// ----- design/crt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_pkg
// Shared types, widths and codes of the congruence solver.
// ============================================================================
package crt_pkg;

    // Field and datapath widths
    localparam int MOD_W  = 16;   // modulus field
    localparam int REM_W  = 32;   // remainder field
    localparam int SOL_W  = 63;   // solution field
    localparam int STAT_W = 2;    // status field
    localparam int PROD_W = 64;   // product of moduli, accumulator
    localparam int WIDE_W = PROD_W + MOD_W;  // plain product before range check

    // Parameter defaults
    localparam int MAX_TERMS_DEF    = 8;
    localparam int MODULUS_BITS_DEF = 16;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_COPRIME  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO     = 2'd3;

    // Input word
    typedef struct packed {
        logic [MOD_W-1:0]        modulus;
        logic signed [REM_W-1:0] remainder;
        logic                    last;
    } crt_in_t;

    // Output word
    typedef struct packed {
        logic [SOL_W-1:0]  solution;
        logic [STAT_W-1:0] status;
    } crt_out_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,        // capture input word
        OP_ERR_ZERO,    // zero modulus seen
        OP_ERR_FULL,    // term beyond capacity
        OP_RED_START,   // start remainder reduction
        OP_PMUL_START,  // start product * modulus
        OP_STORE,       // store term, update product
        OP_SV_INIT,     // clear accumulator and term index
        OP_COF_START,   // start product / m_i
        OP_A_START,     // start cofactor / m_i
        OP_EU_INIT,     // set up extended Euclid
        OP_EUQ_START,   // start r0 / r1
        OP_EU_MUL,      // capture remainder, form q * t1
        OP_EUS_START,   // start (q * t1) mod m_i
        OP_EU_UPD,      // advance Euclid registers
        OP_ERR_COPRIME, // inverse does not exist
        OP_MM1_START,   // start cofactor * remainder mod n
        OP_MM2_START,   // start previous * inverse mod n
        OP_ACC,         // accumulate term, next index
        OP_DONE         // emit result, clear the set
    } crt_op_t;

    // Controller to datapath
    typedef struct packed {
        crt_op_t op;
    } crt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic unit_busy;
        logic m_zero;
        logic full;
        logic last;
        logic err_any;
        logic idx_end;
        logic r1_zero;
        logic r0_one;
    } crt_stat_t;

endpackage

// ----- design/crt_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_div
// Restoring divider, one quotient bit per cycle, 64- or 32-bit dividend.
// ============================================================================
module crt_div
    import crt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              len64,
    input  logic [PROD_W-1:0] dividend,
    input  logic [MOD_W-1:0]  divisor,
    output logic              busy,
    output logic [PROD_W-1:0] quo,
    output logic [MOD_W-1:0]  rem
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [MOD_W-1:0]  dsr_reg, dsr_next;
    logic [MOD_W:0]    shifted;
    logic              ge;

    // one shift-subtract step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PROD_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            dsr_next = divisor;
            rem_next = '0;
            if (len64)
            begin
                quo_next = dividend;
                cnt_next = CNT_W'(PROD_W);
            end
            else
            begin
                quo_next = {dividend[PROD_W/2-1:0], {(PROD_W/2){1'b0}}};
                cnt_next = CNT_W'(PROD_W / 2);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? MOD_W'(shifted - {1'b0, dsr_reg}) : shifted[MOD_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/crt_mop.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_mop
// Shift-add multiplier, plain or modulo n, one multiplier bit per cycle.
// ============================================================================
module crt_mop
    import crt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mod_mode,
    input  logic [PROD_W-1:0] a,
    input  logic [MOD_W-1:0]  b,
    input  logic [PROD_W-1:0] n,
    output logic              busy,
    output logic [WIDE_W-1:0] prod
);

    localparam int CNT_W = $clog2(MOD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] a_reg, a_next;
    logic [MOD_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0] n_reg, n_next;
    logic              mode_reg, mode_next;
    logic [PROD_W:0]   msum, mdbl;

    // one multiplier bit per cycle, LSB first
    always_comb
    begin
        msum      = {1'b0, acc_reg[PROD_W-1:0]} + {1'b0, a_reg[PROD_W-1:0]};
        mdbl      = {a_reg[PROD_W-1:0], 1'b0};
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        mode_next = mode_reg;
        if (start)
        begin
            acc_next  = '0;
            a_next    = WIDE_W'(a);
            b_next    = b;
            n_next    = n;
            mode_next = mod_mode;
            cnt_next  = CNT_W'(MOD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (mode_reg)
            begin
                if (b_reg[0])
                    acc_next = WIDE_W'((msum >= {1'b0, n_reg}) ? msum - {1'b0, n_reg} : msum);
                a_next = WIDE_W'((mdbl >= {1'b0, n_reg}) ? mdbl - {1'b0, n_reg} : mdbl);
            end
            else
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[WIDE_W-2:0], 1'b0};
            end
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        n_reg    <= n_next;
        mode_reg <= mode_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

// ----- design/crt_dpath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_dpath
// Term stores, product, accumulator, Euclid registers and arithmetic units.
// ============================================================================
module crt_dpath
    import crt_pkg::*;
#(
    parameter int MAX_TERMS    = MAX_TERMS_DEF,
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  crt_cmd_t  cmd,
    input  crt_in_t   item,
    output crt_stat_t stat,
    output logic      done,
    output crt_out_t  result
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [MOD_W-1:0] MOD_MASK = (MODULUS_BITS >= MOD_W) ? {MOD_W{1'b1}}
                                          : MOD_W'((64'd1 << MODULUS_BITS) - 64'd1);

    // term stores
    logic [MOD_W-1:0] mst_reg [MAX_TERMS];
    logic [MOD_W-1:0] rst_reg [MAX_TERMS];

    logic [MOD_W-1:0]  m_reg, m_next;
    logic [REM_W-1:0]  src_reg, src_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [STAT_W-1:0] err_reg, err_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0]  mi_reg, mi_next;
    logic [PROD_W-1:0] cof_reg, cof_next;
    logic [MOD_W-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic [MOD_W-1:0]  t0_reg, t0_next, t1_reg, t1_next;
    logic [MOD_W-1:0]  r2_reg, r2_next;
    logic [2*MOD_W-1:0] pq_reg, pq_next;
    logic              done_reg, done_next;
    crt_out_t          res_reg, res_next;

    // unit hookup
    logic              dv_start, dv_len64, dv_busy;
    logic [PROD_W-1:0] dv_dividend, dv_quo;
    logic [MOD_W-1:0]  dv_divisor, dv_rem;
    logic              mo_start, mo_mod, mo_busy;
    logic [PROD_W-1:0] mo_a;
    logic [MOD_W-1:0]  mo_b;
    logic [WIDE_W-1:0] mo_prod;

    logic              wr_en;
    logic [MOD_W-1:0]  red_val, qm, neg_mag;
    logic [MOD_W:0]    tsum;
    logic [PROD_W:0]   asum;
    logic [IDX_W-1:0]  rd_idx, wr_idx;

    function automatic logic [STAT_W-1:0] raise(input logic [STAT_W-1:0] cur,
                                                input logic [STAT_W-1:0] code);
        raise = (code > cur) ? code : cur;
    endfunction

    assign rd_idx = idx_reg[IDX_W-1:0];
    assign wr_idx = cnt_reg[IDX_W-1:0];

    crt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .len64    (dv_len64),
        .dividend (dv_dividend),
        .divisor  (dv_divisor),
        .busy     (dv_busy),
        .quo      (dv_quo),
        .rem      (dv_rem)
    );

    crt_mop u_mop (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mo_start),
        .mod_mode (mo_mod),
        .a        (mo_a),
        .b        (mo_b),
        .n        (prod_reg),
        .busy     (mo_busy),
        .prod     (mo_prod)
    );

    // operation decode
    always_comb
    begin
        neg_mag  = dv_rem;
        red_val  = src_reg[REM_W-1] ? ((neg_mag == '0) ? '0 : m_reg - neg_mag) : dv_rem;
        qm       = (dv_quo[MOD_W-1:0] == mi_reg) ? '0 : dv_quo[MOD_W-1:0];
        tsum     = {1'b0, t0_reg} + {1'b0, mi_reg} - {1'b0, dv_rem};
        asum     = {1'b0, acc_reg} + {1'b0, mo_prod[PROD_W-1:0]};

        m_next    = m_reg;
        src_next  = src_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        err_next  = err_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        mi_next   = mi_reg;
        cof_next  = cof_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        r2_next   = r2_reg;
        pq_next   = pq_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        wr_en     = 1'b0;

        dv_start    = 1'b0;
        dv_len64    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = mi_reg;
        mo_start    = 1'b0;
        mo_mod      = 1'b1;
        mo_a        = cof_reg;
        mo_b        = rst_reg[rd_idx];

        case (cmd.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                m_next    = item.modulus & MOD_MASK;
                src_next  = item.remainder;
                last_next = item.last;
            end
            OP_ERR_ZERO: err_next = raise(err_reg, ST_ZERO);
            OP_ERR_FULL: err_next = raise(err_reg, ST_OVERFLOW);
            OP_RED_START:
            begin
                dv_start    = 1'b1;
                dv_dividend = src_reg[REM_W-1]
                    ? PROD_W'(REM_W'(33'h1_0000_0000 - {1'b0, src_reg}))
                    : PROD_W'(src_reg);
                dv_divisor  = m_reg;
            end
            OP_PMUL_START:
            begin
                mo_start = 1'b1;
                mo_mod   = 1'b0;
                mo_a     = prod_reg;
                mo_b     = m_reg;
            end
            OP_STORE:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (mo_prod[WIDE_W-1:SOL_W] != '0)
                    err_next = raise(err_reg, ST_OVERFLOW);
                else
                    prod_next = mo_prod[PROD_W-1:0];
            end
            OP_SV_INIT:
            begin
                acc_next = '0;
                idx_next = '0;
            end
            OP_COF_START:
            begin
                mi_next     = mst_reg[rd_idx];
                dv_start    = 1'b1;
                dv_len64    = 1'b1;
                dv_dividend = prod_reg;
                dv_divisor  = mst_reg[rd_idx];
            end
            OP_A_START:
            begin
                cof_next    = dv_quo;
                dv_start    = 1'b1;
                dv_len64    = 1'b1;
                dv_dividend = dv_quo;
            end
            OP_EU_INIT:
            begin
                r0_next = mi_reg;
                r1_next = dv_rem;
                t0_next = '0;
                t1_next = (mi_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
            end
            OP_EUQ_START:
            begin
                dv_start    = 1'b1;
                dv_dividend = PROD_W'(r0_reg);
                dv_divisor  = r1_reg;
            end
            OP_EU_MUL:
            begin
                r2_next = dv_rem;
                pq_next = qm * t1_reg;
            end
            OP_EUS_START:
            begin
                dv_start    = 1'b1;
                dv_dividend = PROD_W'(pq_reg);
            end
            OP_EU_UPD:
            begin
                r0_next = r1_reg;
                r1_next = r2_reg;
                t0_next = t1_reg;
                t1_next = (tsum >= {1'b0, mi_reg}) ? MOD_W'(tsum - {1'b0, mi_reg})
                                                   : tsum[MOD_W-1:0];
            end
            OP_ERR_COPRIME: err_next = raise(err_reg, ST_COPRIME);
            OP_MM1_START:   mo_start = 1'b1;
            OP_MM2_START:
            begin
                mo_start = 1'b1;
                mo_a     = mo_prod[PROD_W-1:0];
                mo_b     = t0_reg;
            end
            OP_ACC:
            begin
                acc_next = PROD_W'((asum >= {1'b0, prod_reg}) ? asum - {1'b0, prod_reg}
                                                               : asum);
                idx_next = idx_reg + 1'b1;
            end
            OP_DONE:
            begin
                done_next         = 1'b1;
                res_next.solution = (err_reg == ST_OK) ? acc_reg[SOL_W-1:0] : '0;
                res_next.status   = err_reg;
                cnt_next  = '0;
                prod_next = PROD_W'(1);
                acc_next  = '0;
                err_next  = ST_OK;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idx_reg  <= '0;
            err_reg  <= ST_OK;
            prod_reg <= PROD_W'(1);
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            err_reg  <= err_next;
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        src_reg  <= src_next;
        last_reg <= last_next;
        mi_reg   <= mi_next;
        cof_reg  <= cof_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        r2_reg   <= r2_next;
        pq_reg   <= pq_next;
        res_reg  <= res_next;
        if (wr_en)
        begin
            mst_reg[wr_idx] <= m_reg;
            rst_reg[wr_idx] <= red_val;
        end
    end

    // status to controller
    always_comb
    begin
        stat.unit_busy = dv_busy | mo_busy;
        stat.m_zero    = (m_reg == '0);
        stat.full      = (cnt_reg == CNT_W'(MAX_TERMS));
        stat.last      = last_reg;
        stat.err_any   = (err_reg != ST_OK);
        stat.idx_end   = (idx_reg == cnt_reg);
        stat.r1_zero   = (r1_reg == '0);
        stat.r0_one    = (r0_reg == MOD_W'(1));
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- design/crt_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_ctrl
// Sequencer: load steps per word, then per-term cofactor, inverse, accumulate.
// ============================================================================
module crt_ctrl
    import crt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  crt_stat_t stat,
    output crt_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_LCHK  = 15'b000000000000010,
        S_LDIV  = 15'b000000000000100,
        S_LMUL  = 15'b000000000001000,
        S_LEND  = 15'b000000000010000,
        S_STERM = 15'b000000000100000,
        S_SCOF  = 15'b000000001000000,
        S_SA    = 15'b000000010000000,
        S_ETEST = 15'b000000100000000,
        S_EQ    = 15'b000001000000000,
        S_EM    = 15'b000010000000000,
        S_ES    = 15'b000100000000000,
        S_M1    = 15'b001000000000000,
        S_M2    = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_LCHK;
                end
            S_LCHK:
                if (stat.m_zero)
                begin
                    cmd.op     = OP_ERR_ZERO;
                    state_next = S_LEND;
                end
                else if (stat.full)
                begin
                    cmd.op     = OP_ERR_FULL;
                    state_next = S_LEND;
                end
                else
                begin
                    cmd.op     = OP_RED_START;
                    state_next = S_LDIV;
                end
            S_LDIV:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_PMUL_START;
                    state_next = S_LMUL;
                end
            S_LMUL:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_STORE;
                    state_next = S_LEND;
                end
            S_LEND:
                if (stat.last)
                begin
                    cmd.op     = OP_SV_INIT;
                    state_next = S_STERM;
                end
                else
                    state_next = S_IDLE;
            S_STERM:
                if (stat.err_any || stat.idx_end)
                    state_next = S_OUT;
                else
                begin
                    cmd.op     = OP_COF_START;
                    state_next = S_SCOF;
                end
            S_SCOF:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_A_START;
                    state_next = S_SA;
                end
            S_SA:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_EU_INIT;
                    state_next = S_ETEST;
                end
            S_ETEST:
                if (!stat.r1_zero)
                begin
                    cmd.op     = OP_EUQ_START;
                    state_next = S_EQ;
                end
                else if (!stat.r0_one)
                begin
                    cmd.op     = OP_ERR_COPRIME;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_MM1_START;
                    state_next = S_M1;
                end
            S_EQ:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_EU_MUL;
                    state_next = S_EM;
                end
            S_EM:
            begin
                cmd.op     = OP_EUS_START;
                state_next = S_ES;
            end
            S_ES:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_EU_UPD;
                    state_next = S_ETEST;
                end
            S_M1:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_MM2_START;
                    state_next = S_M2;
                end
            S_M2:
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_ACC;
                    state_next = S_STERM;
                end
            S_OUT:
            begin
                cmd.op     = OP_DONE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/crt_congruence_solver_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// crt_congruence_solver_unit
// Chinese remainder solver over a streamed set of congruences.
// ============================================================================
// A word is taken when start is high and busy is low. Each word keeps busy
// high while a 32-bit divide reduces the remainder and a shift-add multiply
// checks the product of the moduli; the next word is taken only after that.
// The word marked last adds the solve: per term two 64-bit divides (cofactor
// and its residue), an extended Euclid of k steps of two 32-bit divides
// each, and two modular multiplies. The divider is the limiting unit.
// The result word is shown on result for exactly one cycle with done high,
// once the solve finishes; the receiver cannot stall it and must take it in
// that cycle. busy stays high from the accepted word until the block is
// free again.
// ============================================================================
module crt_congruence_solver_unit
    import crt_pkg::*;
#(
    parameter int MAX_TERMS    = MAX_TERMS_DEF,
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  crt_in_t  item,
    output logic     done,
    output crt_out_t result
);

    crt_cmd_t  cmd;
    crt_stat_t stat;

    crt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    crt_dpath #(
        .MAX_TERMS    (MAX_TERMS),
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule
